@@ hdl/tsrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Text space-run compressor package
// Shared widths, character codes, register indexes and the result burst type.
// ----------------------------------------------------------------------------
package tsrc_pkg;

    localparam int BYTE_W  = 8;
    localparam int RUN_W   = 7;
    localparam int BURST_N = 4;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 2;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    localparam logic [RUN_W-1:0]  RUN_LIMIT_RST = 7'd127;
    localparam logic [BYTE_W-1:0] TAB_COUNT_RST = 8'd8;

    typedef enum logic [0:0] {
        REG_RUN_LIMIT = 1'b0,
        REG_TAB_COUNT = 1'b1
    } reg_index_t;

    // Up to four output bytes caused by one input byte, in send order.
    typedef struct packed {
        logic [BURST_N-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               count;
    } burst_t;

endpackage

@@ hdl/tsrc_encode.sv @@
// ----------------------------------------------------------------------------
// Text space-run compressor encoder
// Maps one input byte and the pending space count to its output burst.
// ----------------------------------------------------------------------------
module tsrc_encode
(
    input  logic [7:0]          data_byte,
    input  logic                is_last,
    input  logic [6:0]          space_run,
    input  logic [6:0]          run_limit,
    input  logic [7:0]          tab_space_count,
    output tsrc_pkg::burst_t    burst,
    output logic [6:0]          space_run_next
);

    logic                   is_space;
    logic [6:0]             run_inc;
    logic [6:0]             flush_run;
    logic                   do_flush;
    logic [1:0][7:0]        flush_bytes;
    logic [1:0]             flush_cnt;
    logic [1:0][7:0]        char_bytes;
    logic [1:0]             char_cnt;

    assign is_space = (data_byte == tsrc_pkg::CH_SPACE);
    assign run_inc  = space_run + 7'd1;

    // A space flushes the incremented run at the limit or at end of file;
    // any other byte flushes the run that was pending before it.
    always_comb
    begin
        if (is_space)
        begin
            flush_run      = run_inc;
            do_flush       = (run_inc >= run_limit) || is_last;
            space_run_next = do_flush ? 7'd0 : run_inc;
        end
        else
        begin
            flush_run      = space_run;
            do_flush       = 1'b1;
            space_run_next = 7'd0;
        end
    end

    always_comb
    begin
        flush_bytes = '0;
        flush_cnt   = 2'd0;
        if (do_flush)
        begin
            if (flush_run == 7'd1)
            begin
                flush_bytes[0] = tsrc_pkg::CH_SPACE;
                flush_cnt      = 2'd1;
            end
            else if (flush_run > 7'd1)
            begin
                flush_bytes[0] = tsrc_pkg::CH_TAB;
                flush_bytes[1] = {1'b0, flush_run};
                flush_cnt      = 2'd2;
            end
        end
    end

    always_comb
    begin
        char_bytes = '0;
        char_cnt   = 2'd0;
        if (data_byte > tsrc_pkg::CH_SPACE)
        begin
            char_bytes[0] = data_byte;
            char_cnt      = 2'd1;
        end
        else if (data_byte == tsrc_pkg::CH_LF)
        begin
            char_bytes[0] = tsrc_pkg::CH_CR;
            char_cnt      = 2'd1;
        end
        else if (data_byte == tsrc_pkg::CH_TAB)
        begin
            char_bytes[0] = tsrc_pkg::CH_TAB;
            char_bytes[1] = tab_space_count;
            char_cnt      = 2'd2;
        end
    end

    // Character bytes follow the flushed run bytes.
    always_comb
    begin
        burst.bytes = '0;
        case (flush_cnt)
            2'd0:
            begin
                burst.bytes[0] = char_bytes[0];
                burst.bytes[1] = char_bytes[1];
            end
            2'd1:
            begin
                burst.bytes[0] = flush_bytes[0];
                burst.bytes[1] = char_bytes[0];
                burst.bytes[2] = char_bytes[1];
            end
            2'd2:
            begin
                burst.bytes[0] = flush_bytes[0];
                burst.bytes[1] = flush_bytes[1];
                burst.bytes[2] = char_bytes[0];
                burst.bytes[3] = char_bytes[1];
            end
            default:
            begin
                burst.bytes = '0;
            end
        endcase
        burst.count = {1'b0, flush_cnt} + {1'b0, char_cnt};
    end

endmodule

@@ hdl/text_space_run_compressor_unit.sv @@
// ----------------------------------------------------------------------------
// Text space-run compressor
// Compresses space runs in a text byte stream and converts control bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: data_byte[7:0]; tlast: is_last
//  m_axis    out        tdata: out_byte[7:0];  tlast: run_end
//  cfg       in         index 0 run_limit[6:0], index 1 tab_space_count[7:0]
//
// An input byte is encoded in the cycle it is accepted and its burst of zero
// to four output bytes is loaded into the result register. The burst drains
// one byte per cycle while m_tready is high; a new input byte is taken in the
// same cycle as the last byte of the previous burst, so with m_tready high, the
// rate is one input per cycle when each byte yields at most one output.
// Reset clears the pending run and loads the register defaults.
module text_space_run_compressor_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [6:0]             run_limit_reg;
    logic [7:0]             tab_count_reg;
    logic [6:0]             space_run_reg;
    logic [6:0]             space_run_next;
    tsrc_pkg::burst_t       enc_burst;
    logic [3:0][7:0]        burst_reg;
    logic [2:0]             count_reg;
    logic [1:0]             idx_reg;
    logic                   s_take;
    logic                   m_take;

    tsrc_encode u_encode
    (
        .data_byte       (s_tdata),
        .is_last         (s_tlast),
        .space_run       (space_run_reg),
        .run_limit       (run_limit_reg),
        .tab_space_count (tab_count_reg),
        .burst           (enc_burst),
        .space_run_next  (space_run_next)
    );

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = burst_reg[idx_reg];
    assign m_tlast  = (({1'b0, idx_reg} + 3'd1) == count_reg);
    assign m_take   = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (m_take && m_tlast);
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_limit_reg <= tsrc_pkg::RUN_LIMIT_RST;
            tab_count_reg <= tsrc_pkg::TAB_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tsrc_pkg::REG_RUN_LIMIT: run_limit_reg <= cfg_data[6:0];
                tsrc_pkg::REG_TAB_COUNT: tab_count_reg <= cfg_data;
                default:                 run_limit_reg <= run_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_run_reg <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
        end
        else if (s_take)
        begin
            space_run_reg <= space_run_next;
            count_reg     <= enc_burst.count;
            idx_reg       <= '0;
        end
        else if (m_take)
        begin
            if (m_tlast)
            begin
                count_reg <= '0;
                idx_reg   <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            burst_reg <= enc_burst.bytes;
        end
    end

endmodule

@@ test/text_space_run_compressor_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text space-run compressor testbench
// Streams host text through the compressor under several register settings,
// with bursty input, a stalling output and one long output hold-off. A
// tracker class predicts the compressed bytes and checks each output byte.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} text_item_t;

typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
} out_item_t;

class compressed_stream_tracker;
    logic [6:0] run_limit;
    logic [7:0] tab_count;
    logic [6:0] spaces_held;
    out_item_t  due_bytes[$];
    out_item_t  burst[$];
    int         errors;
    int         bytes_in;
    int         bytes_out;

    function new();
        run_limit   = tsrc_pkg::RUN_LIMIT_RST;
        tab_count   = tsrc_pkg::TAB_COUNT_RST;
        spaces_held = '0;
        errors      = 0;
        bytes_in    = 0;
        bytes_out   = 0;
    endfunction

    function void write_reg(tsrc_pkg::reg_index_t idx, logic [7:0] value);
        if (idx == tsrc_pkg::REG_RUN_LIMIT)
            run_limit = value[6:0];
        else
            tab_count = value;
    endfunction

    function void push_byte(logic [7:0] b);
        out_item_t item;
        item.ch      = b;
        item.run_end = 1'b0;
        burst.push_back(item);
    endfunction

    // A single pending space goes out as itself, a longer run as TAB + count.
    function void flush_spaces();
        if (spaces_held == 7'd1)
        begin
            push_byte(tsrc_pkg::CH_SPACE);
        end
        else if (spaces_held > 7'd1)
        begin
            push_byte(tsrc_pkg::CH_TAB);
            push_byte({1'b0, spaces_held});
        end
        spaces_held = '0;
    endfunction

    function void take_text_byte(logic [7:0] c, logic last);
        burst.delete();
        bytes_in++;
        if (c == tsrc_pkg::CH_SPACE)
        begin
            spaces_held = spaces_held + 7'd1;
            if (spaces_held >= run_limit)
                flush_spaces();
        end
        else
        begin
            flush_spaces();
            if (c > tsrc_pkg::CH_SPACE)
            begin
                push_byte(c);
            end
            else if (c == tsrc_pkg::CH_LF)
            begin
                push_byte(tsrc_pkg::CH_CR);
            end
            else if (c == tsrc_pkg::CH_TAB)
            begin
                push_byte(tsrc_pkg::CH_TAB);
                push_byte(tab_count);
            end
        end
        if (last)
            flush_spaces();
        if (burst.size() > 0)
            burst[burst.size() - 1].run_end = 1'b1;
        foreach (burst[i])
            due_bytes.push_back(burst[i]);
    endfunction

    task report(string msg);
        if (errors < 30)
            $display("%0t ERROR: %s", $time, msg);
        errors++;
    endtask

    task check_out_byte(logic [7:0] got_ch, logic got_end);
        out_item_t want;
        bytes_out++;
        if (due_bytes.size() == 0)
        begin
            report($sformatf("output byte %02h arrived with nothing expected", got_ch));
        end
        else
        begin
            want = due_bytes.pop_front();
            if (got_ch !== want.ch)
                report($sformatf("out_byte %02h, expected %02h", got_ch, want.ch));
            if (got_end !== want.run_end)
                report($sformatf("run_end %0b on byte %02h, expected %0b",
                                 got_end, got_ch, want.run_end));
        end
    endtask
endclass

module text_space_run_compressor_unit_tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // [7:0] data_byte
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = tsrc_pkg::REG_RUN_LIMIT;
    logic [7:0] cfg_data = 8'h00;

    compressed_stream_tracker tracker;
    text_item_t feed[$];
    int  recv_mode = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  rcv_cycle = 0;
    int  idle_cycles = 0;
    int  settings_used = 1;

    text_space_run_compressor_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Output side: check each transaction, then pick readiness for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_out_byte(m_tdata, m_tlast);
        rcv_cycle++;
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (recv_mode == 0)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= !(((rcv_cycle % 13) < 4) || ($urandom_range(0, 4) == 0));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles, %0d bytes still due",
                     IDLE_LIMIT, tracker.due_bytes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task write_regs(logic [6:0] limit, logic [7:0] tab);
        cfg_we    <= 1'b1;
        cfg_index <= tsrc_pkg::REG_RUN_LIMIT;
        cfg_data  <= {1'b0, limit};
        @(posedge clk);
        cfg_index <= tsrc_pkg::REG_TAB_COUNT;
        cfg_data  <= tab;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.write_reg(tsrc_pkg::REG_RUN_LIMIT, {1'b0, limit});
        tracker.write_reg(tsrc_pkg::REG_TAB_COUNT, tab);
        settings_used++;
        @(posedge clk);
    endtask

    task add_byte(logic [7:0] c, logic last);
        text_item_t item;
        item.ch   = c;
        item.last = last;
        feed.push_back(item);
    endtask

    // Words, space runs, line ends and tabs, with some control noise and
    // end-of-file marks sprinkled in.
    task gen_text(int n, bit long_run);
        int pick;
        int len;
        int run_max;
        run_max = (tracker.run_limit > 20) ? 12 : tracker.run_limit + 2;
        if (run_max < 3)
            run_max = 3;
        while (feed.size() < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                    add_byte(8'($urandom_range(8'h21, 8'hFF)), $urandom_range(0, 24) == 0);
            end
            else if (pick < 75)
            begin
                len = $urandom_range(1, run_max);
                repeat (len - 1)
                    add_byte(tsrc_pkg::CH_SPACE, 1'b0);
                add_byte(tsrc_pkg::CH_SPACE, $urandom_range(0, 7) == 0);
            end
            else if (pick < 82)
            begin
                add_byte(tsrc_pkg::CH_LF, $urandom_range(0, 5) == 0);
            end
            else if (pick < 89)
            begin
                add_byte(tsrc_pkg::CH_TAB, $urandom_range(0, 9) == 0);
            end
            else if (pick < 95)
            begin
                add_byte(8'($urandom_range(8'h00, 8'h1F)), $urandom_range(0, 9) == 0);
            end
            else
            begin
                add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        if (long_run)
        begin
            repeat (tracker.run_limit + 3)
                add_byte(tsrc_pkg::CH_SPACE, 1'b0);
            add_byte(8'h2E, 1'b1);
        end
    endtask

    task send_feed(bit bursty);
        text_item_t item;
        int burst_left;
        int gap;
        burst_left = 0;
        while (feed.size() > 0)
        begin
            item = feed.pop_front();
            if (bursty && burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                gap = $urandom_range(0, 5);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            s_tvalid <= 1'b1;
            s_tdata  <= item.ch;
            s_tlast  <= item.last;
            do
                @(posedge clk);
            while (!s_tready);
            tracker.take_text_byte(item.ch, item.last);
        end
        s_tvalid <= 1'b0;
    endtask

    // An extra output byte leaves no trace in the queue, so wait a little beyond it.
    task wait_drained();
        while (tracker.due_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every kind of byte, bursts of up to four, end-of-file.
        recv_mode = 0;
        add_byte(8'h41, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(8'h62, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_LF, 1'b0);
        add_byte(tsrc_pkg::CH_TAB, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_TAB, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_TAB, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h21, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b1);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b1);
        add_byte(8'h78, 1'b0);
        add_byte(tsrc_pkg::CH_SPACE, 1'b0);
        add_byte(tsrc_pkg::CH_CR, 1'b0);
        add_byte(tsrc_pkg::CH_LF, 1'b1);
        send_feed(1'b0);
        wait_drained();

        recv_mode = 1;
        write_regs(7'd2, 8'hFF);
        gen_text(20, 1'b0);
        send_feed(1'b1);
        wait_drained();

        // Limits below two flush every space at once; a zero tab count is sent as is.
        write_regs(7'd1, 8'h00);
        gen_text(12, 1'b0);
        send_feed(1'b1);
        wait_drained();

        recv_mode = 0;
        write_regs(7'd0, 8'h01);
        gen_text(8, 1'b0);
        send_feed(1'b0);
        wait_drained();

        // Hold the output off while input is still offered, and run spaces past the limit.
        recv_mode = 1;
        write_regs(7'd40, 8'($urandom_range(128, 255)));
        gen_text(12, 1'b1);
        hold_request = 1'b1;
        send_feed(1'b0);
        wait_drained();

        write_regs(7'($urandom_range(3, 20)), 8'($urandom_range(1, 255)));
        gen_text(20, 1'b0);
        send_feed(1'b1);
        wait_drained();

        $display("Sent %0d text bytes under %0d register settings, checked %0d output bytes.",
                 tracker.bytes_in, settings_used, tracker.bytes_out);
        $display("Mismatches: %0d", tracker.errors);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tsrc_pkg.sv
hdl/tsrc_encode.sv
hdl/text_space_run_compressor_unit.sv
test/text_space_run_compressor_unit_tb.sv
